// File: rtl/wsp_pkg.sv
// Shared types, widths and helpers for the weighted simplex projection block.
// No dependencies.
package wsp_pkg;

    localparam int MAX_LEN = 64;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = IDX_W + 1;
    localparam int VAL_W   = 32;
    localparam int SC_W    = 48;          // Q32.16 scaled value / threshold
    localparam int WS_W    = 40;          // sum of active weights
    localparam int MAG_W   = SC_W + 1;    // magnitude of a difference of two Q32.16
    localparam int NUM_W   = MAG_W + VAL_W; // product magnitude fed to the divider
    localparam int ENT_W   = SC_W + VAL_W + 1;
    localparam int ADDR_W  = 3;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);
    localparam logic [ADDR_W-1:0] REG_VECTOR_LENGTH = '0;

    typedef struct packed {
        logic signed [SC_W-1:0]  scaled;
        logic        [VAL_W-1:0] weight;
        logic                    active;
    } entry_t;

    typedef struct packed {
        logic               start;
        logic               short_op;   // dividend fits in MAG_W bits
        logic [NUM_W-1:0]   dividend;
        logic [WS_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [MAG_W-1:0]   quotient;   // capped at 2^48
    } div_rsp_t;

    function automatic logic signed [SC_W-1:0] sat48(input logic signed [SC_W+1:0] v);
        logic signed [SC_W+1:0] hi;
        logic signed [SC_W+1:0] lo;
        hi = (SC_W+2)'(signed'({1'b0, {(SC_W-1){1'b1}}}));
        lo = -hi - (SC_W+2)'(1);
        if (v > hi)
        begin
            return hi[SC_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[SC_W-1:0];
        end
        return v[SC_W-1:0];
    endfunction

endpackage

// File: rtl/wsp_if.sv
// Valid/ready channel interfaces for element input and projected output.
// Depends on wsp_pkg.
interface wsp_elem_if;
    import wsp_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  value;
    logic        [VAL_W-1:0]  weight;
    logic signed [VAL_W-1:0]  radius;
    modport source (output valid, value, weight, radius, input ready);
    modport sink   (input valid, value, weight, radius, output ready);
endinterface

interface wsp_res_if;
    import wsp_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  projected;
    logic        [IDX_W-1:0]  element_index;
    logic                     last;
    modport source (output valid, projected, element_index, last, input ready);
    modport sink   (input valid, projected, element_index, last, output ready);
endinterface

// File: rtl/wsp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module wsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: rtl/wsp_div.sv
// Restoring divider, one quotient bit per cycle, quotient capped at 2^48.
// Depends on wsp_pkg.
module wsp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  wsp_pkg::div_req_t  req,
    output wsp_pkg::div_rsp_t  rsp
);
    import wsp_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);
    localparam int Q_W   = MAG_W - 1;

    logic [NUM_W-1:0] num_reg, num_next;
    logic [WS_W-1:0]  rem_reg, rem_next;
    logic [WS_W-1:0]  dsr_reg, dsr_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WS_W:0]    trial;
    logic             bit_q;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[NUM_W-1]};
        bit_q     = (trial >= {1'b0, dsr_reg});
        if (req.start)
        begin
            busy_next = 1'b1;
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            dsr_next  = req.divisor;
            if (req.short_op)
            begin
                num_next = {req.dividend[MAG_W-1:0], {VAL_W{1'b0}}};
                cnt_next = CNT_W'(MAG_W - 1);
            end
            else
            begin
                num_next = req.dividend;
                cnt_next = CNT_W'(NUM_W - 1);
            end
        end
        else if (busy_reg)
        begin
            rem_next = bit_q ? WS_W'(trial - {1'b0, dsr_reg}) : trial[WS_W-1:0];
            q_next   = {q_reg[Q_W-2:0], bit_q};
            if (bit_q && cnt_reg >= CNT_W'(Q_W))
            begin
                ovf_next = 1'b1;
            end
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = ovf_reg ? {1'b1, {Q_W{1'b0}}} : {1'b0, q_reg};
endmodule

// File: rtl/weighted_simplex_projection.sv
// Weighted simplex projection: top level with sequencer, element store and APB port.
// Depends on wsp_pkg, wsp_if, wsp_ram and wsp_div.
//
// Usage:
//   elem  : one vector element per transfer (value, weight, radius; radius is
//           taken with element 0 only). ready is high while the block is idle.
//   res   : one transfer per element once the whole vector has loaded,
//           element_index 0..n-1, last on the final one.
//   APB   : register 0 (byte address 0) holds vector_length, reset 16.
// Sequence: each load runs the value/weight divide; element 0 adds a second
//   divide for the start threshold, and an element that joins the active set
//   adds a multiply plus a divide for the threshold update, all before ready
//   rises again.
// After the last element the block sweeps the element store, one read per
//   element per pass, plus a multiply and a divide for each dropped element
//   that leaves a nonzero weight sum, until a pass drops nothing; then it
//   emits the results in index order. One serial divider serves every divide.
// Reset empties the block and sets vector_length to 16; the store needs no clear.
// A stalled receiver holds the output register; the sequencer waits on it, and
//   the last result may still wait there while the next vector starts loading.
module weighted_simplex_projection (
    input  logic                         clk,
    input  logic                         rst_n,
    wsp_elem_if.sink                     elem,
    wsp_res_if.source                    res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wsp_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import wsp_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIV_S    = 4'd1;
    localparam logic [3:0] S_DIV_T    = 4'd2;
    localparam logic [3:0] S_MUL0     = 4'd3;
    localparam logic [3:0] S_MUL1     = 4'd4;
    localparam logic [3:0] S_SDIV     = 4'd5;
    localparam logic [3:0] S_LOAD_END = 4'd6;
    localparam logic [3:0] S_P_RD     = 4'd7;
    localparam logic [3:0] S_P_CHK    = 4'd8;
    localparam logic [3:0] S_P_NEXT   = 4'd9;
    localparam logic [3:0] S_O_RD     = 4'd10;
    localparam logic [3:0] S_O_DIFF   = 4'd11;
    localparam logic [3:0] S_O_MUL0   = 4'd12;
    localparam logic [3:0] S_O_MUL1   = 4'd13;
    localparam logic [3:0] S_O_EMIT   = 4'd14;

    logic [3:0]              state_reg, state_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [LEN_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic signed [VAL_W-1:0] v_reg, v_next;
    logic [VAL_W-1:0]        w_reg, w_next;
    logic signed [VAL_W-1:0] r_reg, r_next;
    logic signed [SC_W-1:0]  tau_reg, tau_next;
    logic [WS_W-1:0]         ws_reg, ws_next;
    logic [IDX_W-1:0]        d_reg, d_next;
    logic [IDX_W-1:0]        nlast_reg, nlast_next;
    logic                    chg_reg, chg_next;
    logic                    ret_reg, ret_next;   // update returns to removal pass
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic [VAL_W-1:0]        m_reg, m_next;
    logic [NUM_W-1:0]        prod_reg, prod_next;
    logic                    neg_reg, neg_next;
    logic                    act_reg, act_next;
    div_req_t                dreq_reg, dreq_next;
    logic                    ov_reg, ov_next;
    logic signed [VAL_W-1:0] oproj_reg, oproj_next;
    logic [IDX_W-1:0]        oidx_reg, oidx_next;
    logic                    olast_reg, olast_next;

    div_rsp_t                drsp;
    logic                    mem_we, mem_re;
    logic [IDX_W-1:0]        mem_waddr, mem_raddr;
    entry_t                  mem_wdata, mem_rdata;
    logic [ENT_W-1:0]        mem_rraw;

    logic                    cfg_wr;
    logic [LEN_W-1:0]        len_eff;
    logic [VAL_W-1:0]        in_w;
    logic [VAL_W-1:0]        v_mag;
    logic [VAL_W:0]          vr_diff;
    logic [VAL_W:0]          vr_mag;
    logic signed [SC_W-1:0]  sc_new;
    logic signed [SC_W:0]    sdiff;
    logic [WS_W-1:0]         ws_drop;
    logic [2*VAL_W-1:0]      pp0;
    logic [MAG_W-1:0]        pp1;
    logic signed [SC_W+1:0]  tau_sum;
    logic signed [SC_W+1:0]  tau_start;
    logic [NUM_W-VAL_W/2-1:0] pscaled;
    logic signed [VAL_W-1:0] proj_val;

    wsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq_reg),
        .rsp   (drsp)
    );

    wsp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rraw)
    );
    assign mem_rdata = entry_t'(mem_rraw);

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_VECTOR_LENGTH[ADDR_W-1]);
    assign prdata = {{(32-LEN_W){1'b0}}, len_reg};

    assign elem.ready        = (state_reg == S_IDLE);
    assign res.valid         = ov_reg;
    assign res.projected     = oproj_reg;
    assign res.element_index = oidx_reg;
    assign res.last          = olast_reg;

    always_comb
    begin
        len_eff = len_reg;
        if (len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_LEN))
        begin
            len_eff = LEN_W'(MAX_LEN);
        end
    end

    assign in_w    = (elem.weight == '0) ? VAL_W'(1) : elem.weight;
    assign v_mag   = elem.value[VAL_W-1] ? VAL_W'(-elem.value) : elem.value;
    assign vr_diff = (VAL_W+1)'(v_reg) - (VAL_W+1)'(r_reg);
    assign vr_mag  = vr_diff[VAL_W] ? (VAL_W+1)'(-vr_diff) : vr_diff;
    assign sc_new  = v_reg[VAL_W-1] ? SC_W'(-drsp.quotient[SC_W-1:0])
                                    : signed'(drsp.quotient[SC_W-1:0]);
    assign pp0     = mag_reg[VAL_W-1:0] * m_reg;
    assign pp1     = MAG_W'(mag_reg[MAG_W-1:VAL_W] * m_reg);
    assign tau_sum = (SC_W+2)'(tau_reg) + signed'((SC_W+2)'(drsp.quotient));
    assign tau_start = vr_diff[VAL_W] ? -signed'((SC_W+2)'(drsp.quotient))
                                      : signed'((SC_W+2)'(drsp.quotient));
    assign ws_drop = ws_reg - WS_W'(mem_rdata.weight);
    assign pscaled = prod_reg[NUM_W-1:VAL_W/2];

    always_comb
    begin
        if (!act_reg)
        begin
            proj_val = '0;
        end
        else if (neg_reg)
        begin
            proj_val = (pscaled > (NUM_W-VAL_W/2)'(33'h0_8000_0000))
                     ? signed'({1'b1, {(VAL_W-1){1'b0}}})
                     : VAL_W'(-pscaled[VAL_W-1:0]);
        end
        else
        begin
            proj_val = (pscaled > (NUM_W-VAL_W/2)'(32'h7FFF_FFFF))
                     ? signed'({1'b0, {(VAL_W-1){1'b1}}})
                     : signed'(pscaled[VAL_W-1:0]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = cfg_wr ? pwdata[LEN_W-1:0] : len_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        r_next     = r_reg;
        tau_next   = tau_reg;
        ws_next    = ws_reg;
        d_next     = d_reg;
        nlast_next = nlast_reg;
        chg_next   = chg_reg;
        ret_next   = ret_reg;
        mag_next   = mag_reg;
        m_next     = m_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        act_next   = act_reg;
        dreq_next  = dreq_reg;
        dreq_next.start = 1'b0;
        ov_next    = ov_reg && !res.ready;
        oproj_next = oproj_reg;
        oidx_next  = oidx_reg;
        olast_next = olast_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = d_reg;
        sdiff      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (elem.valid)
                begin
                    v_next   = elem.value;
                    w_next   = in_w;
                    r_next   = elem.radius;
                    idx_next = (count_reg >= LEN_W'(MAX_LEN)) ? IDX_W'(MAX_LEN - 1)
                                                              : count_reg[IDX_W-1:0];
                    dreq_next.start    = 1'b1;
                    dreq_next.short_op = 1'b1;
                    dreq_next.dividend = NUM_W'({v_mag, 16'b0});
                    dreq_next.divisor  = WS_W'(in_w);
                    state_next = S_DIV_S;
                end
            end
            S_DIV_S:
            begin
                if (drsp.done)
                begin
                    mem_we           = 1'b1;
                    mem_wdata.scaled = sc_new;
                    mem_wdata.weight = w_reg;
                    sdiff            = (SC_W+1)'(sc_new) - (SC_W+1)'(tau_reg);
                    if (idx_reg == '0)
                    begin
                        mem_wdata.active   = 1'b1;
                        dreq_next.start    = 1'b1;
                        dreq_next.short_op = 1'b1;
                        dreq_next.dividend = NUM_W'({vr_mag, 16'b0});
                        dreq_next.divisor  = WS_W'(w_reg);
                        state_next = S_DIV_T;
                    end
                    else if (sc_new > tau_reg)
                    begin
                        mem_wdata.active = 1'b1;
                        ws_next    = ws_reg + WS_W'(w_reg);
                        mag_next   = MAG_W'(sdiff);
                        m_next     = w_reg;
                        ret_next   = 1'b0;
                        state_next = S_MUL0;
                    end
                    else
                    begin
                        mem_wdata.active = 1'b0;
                        state_next = S_LOAD_END;
                    end
                end
            end
            S_DIV_T:
            begin
                if (drsp.done)
                begin
                    tau_next   = sat48(tau_start);
                    ws_next    = WS_W'(w_reg);
                    state_next = S_LOAD_END;
                end
            end
            S_MUL0:
            begin
                prod_next  = NUM_W'(pp0);
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                prod_next          = prod_reg + {pp1, {VAL_W{1'b0}}};
                dreq_next.start    = 1'b1;
                dreq_next.short_op = 1'b0;
                dreq_next.dividend = prod_next;
                dreq_next.divisor  = ws_reg;
                state_next = S_SDIV;
            end
            S_SDIV:
            begin
                if (drsp.done)
                begin
                    tau_next   = sat48(tau_sum);
                    state_next = ret_reg ? S_P_NEXT : S_LOAD_END;
                end
            end
            S_LOAD_END:
            begin
                if ((LEN_W'(idx_reg) + LEN_W'(1)) >= len_eff)
                begin
                    nlast_next = idx_reg;
                    d_next     = '0;
                    chg_next   = 1'b0;
                    state_next = S_P_RD;
                end
                else
                begin
                    count_next = LEN_W'(idx_reg) + LEN_W'(1);
                    state_next = S_IDLE;
                end
            end
            S_P_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                state_next = S_P_NEXT;
                if (mem_rdata.active && (mem_rdata.scaled < tau_reg))
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = d_reg;
                    mem_wdata        = mem_rdata;
                    mem_wdata.active = 1'b0;
                    ws_next          = ws_drop;
                    chg_next         = 1'b1;
                    if (ws_drop != '0)
                    begin
                        sdiff      = (SC_W+1)'(tau_reg) - (SC_W+1)'(mem_rdata.scaled);
                        mag_next   = MAG_W'(sdiff);
                        m_next     = mem_rdata.weight;
                        ret_next   = 1'b1;
                        state_next = S_MUL0;
                    end
                end
            end
            S_P_NEXT:
            begin
                if (d_reg == nlast_reg)
                begin
                    d_next     = '0;
                    chg_next   = 1'b0;
                    state_next = chg_reg ? S_P_RD : S_O_RD;
                end
                else
                begin
                    d_next     = d_reg + IDX_W'(1);
                    state_next = S_P_RD;
                end
            end
            S_O_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_O_DIFF;
            end
            S_O_DIFF:
            begin
                sdiff      = (SC_W+1)'(mem_rdata.scaled) - (SC_W+1)'(tau_reg);
                neg_next   = sdiff[SC_W];
                mag_next   = sdiff[SC_W] ? MAG_W'(-sdiff) : MAG_W'(sdiff);
                m_next     = mem_rdata.weight;
                act_next   = mem_rdata.active;
                state_next = S_O_MUL0;
            end
            S_O_MUL0:
            begin
                prod_next  = NUM_W'(pp0);
                state_next = S_O_MUL1;
            end
            S_O_MUL1:
            begin
                prod_next  = prod_reg + {pp1, {VAL_W{1'b0}}};
                state_next = S_O_EMIT;
            end
            S_O_EMIT:
            begin
                if (!ov_reg || res.ready)
                begin
                    ov_next    = 1'b1;
                    oproj_next = proj_val;
                    oidx_next  = d_reg;
                    olast_next = (d_reg == nlast_reg);
                    if (d_reg == nlast_reg)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg + IDX_W'(1);
                        state_next = S_O_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= LEN_RESET;
            count_reg <= '0;
            tau_reg   <= '0;
            ws_reg    <= '0;
            chg_reg   <= 1'b0;
            ret_reg   <= 1'b0;
            dreq_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            tau_reg   <= tau_next;
            ws_reg    <= ws_next;
            chg_reg   <= chg_next;
            ret_reg   <= ret_next;
            dreq_reg  <= dreq_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        v_reg     <= v_next;
        w_reg     <= w_next;
        r_reg     <= r_next;
        d_reg     <= d_next;
        nlast_reg <= nlast_next;
        mag_reg   <= mag_next;
        m_reg     <= m_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        act_reg   <= act_next;
        oproj_reg <= oproj_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
    end
endmodule

// File: rtl/wsp_checker.sv
// Port-level checks for the weighted simplex projection block, bound to the top level.
// Depends on wsp_pkg and wsp_if.
module wsp_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    wsp_elem_if.sink                     elem,
    wsp_res_if.source                    res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wsp_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata
);
    import wsp_pkg::*;

    // a waiting result holds until its transfer
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.projected))
        else $error("result dropped or changed while stalled");

    // one element at a time: input closes right after a transfer
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        elem.valid && elem.ready |=> !elem.ready)
        else $error("input still open after a transfer");

    // the length register reads back what was written
    a_cfg_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[ADDR_W-1]
        |=> prdata[LEN_W-1:0] == $past(pwdata[LEN_W-1:0]))
        else $error("vector_length readback mismatch");

    // the top element index always closes a vector
    a_last_top: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.element_index == IDX_W'(MAX_LEN - 1)) |-> res.last)
        else $error("final element index without last");
endmodule

bind weighted_simplex_projection wsp_checker u_wsp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .elem    (elem),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
);

// File: verif/weighted_simplex_projection_tb.sv
// Testbench for weighted_simplex_projection: directed and random vectors checked
// against a bit-exact projection predictor held in a small scoreboard class.
// Depends on wsp_pkg, wsp_if and the RTL of the block.
`timescale 1ns / 1ps

module weighted_simplex_projection_tb;
    import wsp_pkg::*;

    localparam longint Q48_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint Q48_MIN = -64'sh8000_0000_0000;

    typedef struct {
        logic signed [31:0] projected;
        logic [IDX_W-1:0]   element_index;
        logic               last;
    } proj_t;

    int unsigned error_count = 0;

    task automatic report(input string what);
        error_count++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Predictor of the projection; holds its own copy of the store and tau.
    class proj_scoreboard;
        longint     scaled[MAX_LEN];
        longint     wgt[MAX_LEN];
        bit         act[MAX_LEN];
        longint     tau;
        longint     wsum;
        int         count;
        int         vec_len = 16;
        proj_t      pending[$];
        int         results_seen;
        int         vectors_done;

        function longint sat48(input longint v);
            if (v > Q48_MAX) return Q48_MAX;
            if (v < Q48_MIN) return Q48_MIN;
            return v;
        endfunction

        // trunc(mag*m/s), capped at 2^48
        function longint scaled_quot(input longint unsigned mag, input longint unsigned m,
                                     input longint unsigned s);
            logic [127:0] p;
            logic [127:0] q;
            p = 128'(mag) * 128'(m);
            q = p / 128'(s);
            if (q >= (128'd1 << 48)) return longint'(64'd1 << 48);
            return longint'(q[63:0]);
        endfunction

        function void move_tau(input longint diff, input longint unsigned m,
                               input longint unsigned s);
            longint unsigned mag;
            longint q;
            if (s == 0) return;
            mag = diff < 0 ? -diff : diff;
            q = scaled_quot(mag, m, s);
            tau = diff < 0 ? sat48(tau - q) : sat48(tau + q);
        endfunction

        function logic signed [31:0] out_of(input int d);
            longint diff;
            longint unsigned mag;
            logic [127:0] p;
            logic [127:0] sh;
            if (!act[d]) return 0;
            diff = scaled[d] - tau;
            mag = diff < 0 ? -diff : diff;
            p = 128'(mag) * 128'(wgt[d]);
            sh = p >> 16;
            if (diff < 0)
            begin
                if (sh > 128'h8000_0000) sh = 128'h8000_0000;
                return 32'(-longint'(sh[63:0]));
            end
            if (sh > 128'h7FFF_FFFF) sh = 128'h7FFF_FFFF;
            return 32'(sh[63:0]);
        endfunction

        function void note_element(input logic signed [31:0] v_in, input logic [31:0] w_in,
                                   input logic signed [31:0] r_in);
            longint v;
            longint r;
            longint w;
            int len;
            int idx;
            int n;
            bit changed;
            proj_t e;
            v = v_in;
            r = r_in;
            w = longint'({32'd0, w_in});
            len = vec_len;
            idx = count;
            if (len == 0) len = 1;
            if (len > MAX_LEN) len = MAX_LEN;
            if (idx >= MAX_LEN) idx = MAX_LEN - 1;
            if (w == 0) w = 1;
            scaled[idx] = (v * 65536) / w;
            wgt[idx] = w;
            if (idx == 0)
            begin
                tau = sat48(((v - r) * 65536) / w);
                wsum = w;
                act[0] = 1;
            end
            else if (scaled[idx] > tau)
            begin
                act[idx] = 1;
                wsum += w;
                move_tau(scaled[idx] - tau, w, wsum);
            end
            else
            begin
                act[idx] = 0;
            end
            count = idx + 1;
            if (count < len) return;
            n = count;
            do
            begin
                changed = 0;
                for (int d = 0; d < n; d++)
                begin
                    if (act[d] && scaled[d] < tau)
                    begin
                        act[d] = 0;
                        wsum -= wgt[d];
                        move_tau(tau - scaled[d], wgt[d], wsum);
                        changed = 1;
                    end
                end
            end
            while (changed);
            for (int d = 0; d < n; d++)
            begin
                e.projected = out_of(d);
                e.element_index = IDX_W'(d);
                e.last = (d == n - 1);
                pending.push_back(e);
            end
            count = 0;
            vectors_done++;
        endfunction

        task check_result(input logic signed [31:0] p, input logic [IDX_W-1:0] ix,
                          input logic lst);
            proj_t e;
            results_seen++;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result idx %0d value %h", ix, p));
                return;
            end
            e = pending.pop_front();
            if (p !== e.projected)
                report($sformatf("idx %0d projected %h, want %h", e.element_index, p,
                                 e.projected));
            if (ix !== e.element_index)
                report($sformatf("element_index %0d, want %0d", ix, e.element_index));
            if (lst !== e.last)
                report($sformatf("idx %0d last %b, want %b", e.element_index, lst, e.last));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    wsp_elem_if elem ();
    wsp_res_if  res ();

    weighted_simplex_projection dut (
        .clk(clk), .rst_n(rst_n), .elem(elem.sink), .res(res.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    proj_scoreboard sb = new();
    int send_idle_pct = 0;   // percent of cycles the sender sits idle
    int recv_stall_pct = 0;  // percent of cycles the receiver stalls
    int elements_sent = 0;

    // Receiver: random stalls, checks every transfer on the output channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res.ready)
                sb.check_result(res.projected, res.element_index, res.last);
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        else
        begin
            res.ready <= 0;
        end
    end

    // One element transfer, with random idle cycles ahead of it.
    // valid stays up after the transfer; drain() drops it once a burst ends.
    task automatic send_element(input logic [31:0] v, input logic [31:0] w,
                                input logic [31:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            elem.valid <= 0;
            @(posedge clk);
        end
        elem.valid <= 1;
        elem.value <= v;
        elem.weight <= w;
        elem.radius <= r;
        do
            @(posedge clk);
        while (!elem.ready);
        sb.note_element(v, w, r);
        elements_sent++;
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [31:0] d);
        psel <= 1;
        pwrite <= 1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // Idle point: all results in, then let any tail work settle.
    task automatic drain();
        elem.valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_length(input int len);
        drain();
        apb_write(REG_VECTOR_LENGTH, 32'(len));
        sb.vec_len = len & 7'h7F;
    endtask

    // Mostly well-formed weights around 1.0 so active sets vary; some extremes.
    function automatic logic [31:0] rand_weight();
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(3);
            2: return 32'hFFFF_FFFF;
            default: return 32'h8000 + $urandom_range(32'h3_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(7))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(32'h10_0000)) - 32'sh8_0000);
        endcase
    endfunction

    task automatic send_vector(input int n);
        for (int i = 0; i < n; i++)
            send_element(rand_value(), rand_weight(),
                         ($urandom_range(3) == 0) ? $urandom()
                                                  : 32'($urandom_range(32'h4_0000)));
    endtask

    initial
    begin
        int len;
        elem.valid = 0;
        elem.value = '0;
        elem.weight = '0;
        elem.radius = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: reset length of 16 with extremes of every field.
        send_element(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_element(32'h8000_0000, 32'h0000_0001, 32'h0);
        send_element(32'h7FFF_FFFF, 32'h0000_0001, 32'h0);   // huge tau update
        send_element(32'h0001_0000, 32'h0000_0000, 32'h0);   // zero weight
        send_element(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF);
        send_element(32'h0, 32'h0001_0000, 32'h7FFF_FFFF);
        for (int i = 0; i < 10; i++)
            send_element(32'(i << 15), 32'h0001_0000, 32'h0);
        // Length zero acts as one; above the maximum acts as the maximum.
        set_length(0);
        send_element(32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
        set_length(1);
        send_element(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        set_length(2);
        send_element(32'h0003_0000, 32'h0001_0000, 32'h0001_0000);
        send_element(32'h0001_0000, 32'h0001_0000, 32'h0);  // below the start threshold, never active
        set_length(127);
        send_vector(64);
        // Length lowered mid-vector: next load ends the vector.
        set_length(8);
        send_vector(4);
        set_length(2);
        send_vector(1);

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 47 : (ph == 3) ? 14 : 0;
            recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 14 : 0;
            for (int v = 0; v < 2; v++)
            begin
                len = ($urandom_range(5) == 0) ? 64 : $urandom_range(1, 12);
                set_length(len);
                send_vector(len);
                if (v == 1)
                    drain();   // sender holds off until every result is back
            end
        end
        drain();
        $display("Covered %0d elements in %0d vectors, %0d results checked.",
                 elements_sent, sb.vectors_done, sb.results_seen);
        if (error_count == 0 && sb.pending.size() == 0)
            $display("weighted_simplex_projection_tb: clean");
        else
            $display("weighted_simplex_projection_tb: errors");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("weighted_simplex_projection_tb: errors");
        $finish;
    end
endmodule

// File: filelist.f
rtl/wsp_pkg.sv
rtl/wsp_if.sv
rtl/wsp_ram.sv
rtl/wsp_div.sv
rtl/weighted_simplex_projection.sv
rtl/wsp_checker.sv
verif/weighted_simplex_projection_tb.sv
